// ===== src/rmq_pkg.sv =====
// Shared types, constants and width helpers for the rotation-matrix-to-quaternion block
package rmq_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 30;
  localparam int NUM_W         = 34;
  localparam int MAG_W         = 33;
  localparam int QUO_W         = 34;
  localparam int LANES         = 3;
  localparam int ELEMS         = 9;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_t;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [NUM_W-1:0]  num_t;
  typedef logic [QUO_W-1:0]         quo_t;

  typedef struct packed {
    case_t                  cs;
    logic                   degen;
    num_t [LANES-1:0]       num;
  } tag_t;

  typedef struct packed {
    case_t                  cs;
    logic                   degen;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       nz;
    logic [LANES-1:0]       ovf;
  } side_t;

  localparam data_t OUT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t OUT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // radicand width: holds three elements plus one
  function automatic int rad_w(int fb);
    return (fb > 32) ? fb + 2 : 35;
  endfunction

  // root width: half of the scaled radicand, rounded up
  function automatic int root_w(int fb);
    return (rad_w(fb) + fb + 1) >> 1;
  endfunction

endpackage

// ===== src/rmq_if.sv =====
// Handshake channels for matrices in and quaternions out
interface rmq_mat_if;
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  data_t row0_col0, row0_col1, row0_col2;
  data_t row1_col0, row1_col1, row1_col2;
  data_t row2_col0, row2_col1, row2_col2;
  modport source (output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                  row1_col2, row2_col0, row2_col1, row2_col2, input ready);
  modport sink (input valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
                row1_col2, row2_col0, row2_col1, row2_col2, output ready);
endinterface

interface rmq_quat_if;
  import rmq_pkg::*;
  logic       valid;
  logic       ready;
  data_t      quat_x, quat_y, quat_z, quat_w;
  logic [1:0] case_taken;
  logic       degenerate;
  modport source (output valid, quat_x, quat_y, quat_z, quat_w, case_taken, degenerate,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w, case_taken, degenerate,
                output ready);
endinterface

// ===== src/rmq_front.sv =====
// Case selection, radicand and numerator formation
module rmq_front import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int RW        = rad_w(FRAC_BITS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  data_t [ELEMS-1:0]  elem,
  output logic               valid,
  output logic [RW-1:0]      rad,
  output tag_t               tag
);

  localparam logic signed [RW:0] ONE = (RW+1)'(1) << FRAC_BITS;

  logic signed [RW:0] e00, e11, e22, trace, rs;
  num_t               a01, a02, a10, a12, a20, a21;
  case_t              cs;
  tag_t               tag_next;

  always_comb begin
    e00 = (RW+1)'(elem[0]);
    e11 = (RW+1)'(elem[4]);
    e22 = (RW+1)'(elem[8]);
    a01 = num_t'(elem[1]);
    a02 = num_t'(elem[2]);
    a10 = num_t'(elem[3]);
    a12 = num_t'(elem[5]);
    a20 = num_t'(elem[6]);
    a21 = num_t'(elem[7]);
    trace = e00 + e11 + e22;
    if (trace > 0) begin
      cs = CASE_TRACE;
    end else if (elem[0] > elem[4] && elem[0] > elem[8]) begin
      cs = CASE_X;
    end else if (elem[4] > elem[8]) begin
      cs = CASE_Y;
    end else begin
      cs = CASE_Z;
    end
    tag_next.cs = cs;
    case (cs)
      CASE_TRACE: begin
        rs = trace + ONE;
        tag_next.num[0] = a21 - a12;
        tag_next.num[1] = a02 - a20;
        tag_next.num[2] = a10 - a01;
      end
      CASE_X: begin
        rs = ONE + e00 - e11 - e22;
        tag_next.num[0] = a01 + a10;
        tag_next.num[1] = a02 + a20;
        tag_next.num[2] = a21 - a12;
      end
      CASE_Y: begin
        rs = ONE + e11 - e00 - e22;
        tag_next.num[0] = a01 + a10;
        tag_next.num[1] = a12 + a21;
        tag_next.num[2] = a02 - a20;
      end
      default: begin
        rs = ONE + e22 - e00 - e11;
        tag_next.num[0] = a02 + a20;
        tag_next.num[1] = a12 + a21;
        tag_next.num[2] = a10 - a01;
      end
    endcase
    tag_next.degen = rs[RW] || (rs == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      rad <= rs[RW] ? '0 : rs[RW-1:0];
      tag <= tag_next;
    end
  end

endmodule

// ===== src/rmq_sqrt.sv =====
// Pipelined digit-by-digit square root, one root bit per stage
module rmq_sqrt import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int RW        = rad_w(FRAC_BITS),
  parameter int HW        = root_w(FRAC_BITS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] rad,
  input  tag_t          in_tag,
  output logic          valid,
  output logic [HW-1:0] root,
  output tag_t          tag
);

  localparam int SW = 2 * HW;

  logic [SW-1:0] xs  [0:HW];
  logic [HW+1:0] rem [0:HW];
  logic [HW-1:0] rt  [0:HW];
  tag_t          tg  [0:HW];
  logic          vs  [0:HW];

  assign xs[0]  = SW'(rad) << FRAC_BITS;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign tg[0]  = in_tag;
  assign vs[0]  = in_valid;

  for (genvar i = 0; i < HW; i++) begin : g_stage
    logic [HW+3:0] cur, trial;
    assign cur   = {rem[i], xs[i][SW-1 -: 2]};
    assign trial = (HW+4)'({rt[i], 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
      if (en) begin
        xs[i+1] <= xs[i] << 2;
        tg[i+1] <= tg[i];
        if (cur >= trial) begin
          rem[i+1] <= (HW+2)'(cur - trial);
          rt[i+1]  <= {rt[i][HW-2:0], 1'b1};
        end else begin
          rem[i+1] <= (HW+2)'(cur);
          rt[i+1]  <= {rt[i][HW-2:0], 1'b0};
        end
      end
    end
  end

  assign valid = vs[HW];
  assign root  = rt[HW];
  assign tag   = tg[HW];

endmodule

// ===== src/rmq_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage
module rmq_div import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int HW        = root_w(FRAC_BITS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [HW-1:0]     root,
  input  tag_t              in_tag,
  output logic              valid,
  output logic [HW-1:0]     h,
  output side_t             side,
  output quo_t [LANES-1:0]  quo
);

  localparam int DVW = MAG_W + FRAC_BITS;
  localparam int HIW = DVW - QUO_W;
  localparam int CW  = (HIW > HW) ? HIW : HW;

  logic [HW-1:0] rem [0:QUO_W][LANES];
  quo_t          dlo [0:QUO_W][LANES];
  quo_t          q   [0:QUO_W][LANES];
  logic [HW-1:0] hs  [0:QUO_W];
  side_t         sd  [0:QUO_W];
  logic          vs  [0:QUO_W];

  side_t side_next;

  always_comb begin
    side_next.cs    = in_tag.cs;
    side_next.degen = in_tag.degen;
    for (int l = 0; l < LANES; l++) begin
      side_next.neg[l] = in_tag.num[l][NUM_W-1];
      side_next.nz[l]  = (in_tag.num[l] != '0);
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_init
    logic [MAG_W-1:0] mag;
    logic [DVW-1:0]   dvd;
    assign mag = MAG_W'(in_tag.num[l][NUM_W-1] ? -in_tag.num[l] : in_tag.num[l]);
    assign dvd = {mag, {FRAC_BITS{1'b0}}};
    assign side_next.ovf[l] = CW'(dvd[DVW-1:QUO_W]) >= CW'(root);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[0][l] <= HW'(dvd[DVW-1:QUO_W]);
        dlo[0][l] <= dvd[QUO_W-1:0];
        q[0][l]   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (en) begin
      vs[0] <= in_valid;
    end
    if (en) begin
      hs[0] <= root;
      sd[0] <= side_next;
    end
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
      if (en) begin
        hs[i+1] <= hs[i];
        sd[i+1] <= sd[i];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [HW:0] cur;
      assign cur = {rem[i][l], dlo[i][l][QUO_W-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          dlo[i+1][l] <= dlo[i][l] << 1;
          if (cur >= {1'b0, hs[i]}) begin
            rem[i+1][l] <= HW'(cur - {1'b0, hs[i]});
            q[i+1][l]   <= {q[i][l][QUO_W-2:0], 1'b1};
          end else begin
            rem[i+1][l] <= HW'(cur);
            q[i+1][l]   <= {q[i][l][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign valid = vs[QUO_W];
  assign h     = hs[QUO_W];
  assign side  = sd[QUO_W];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo[l] = q[QUO_W][l];
  end

endmodule

// ===== src/rmq_back.sv =====
// Rounding, saturation and component placement into the output register
module rmq_back import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int HW        = root_w(FRAC_BITS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [HW-1:0]    h,
  input  side_t            side,
  input  quo_t [LANES-1:0] quo,
  output logic             valid,
  output data_t            quat_x,
  output data_t            quat_y,
  output data_t            quat_z,
  output data_t            quat_w,
  output logic [1:0]       case_taken,
  output logic             degenerate
);

  localparam quo_t POS_LIM = QUO_W'(OUT_MAX);
  localparam quo_t NEG_LIM = POS_LIM + QUO_W'(1);

  data_t         lv [LANES];
  data_t         diag;
  logic [HW:0]   hh;

  always_comb begin
    hh   = (HW+1)'(h) + (HW+1)'(1);
    diag = ((HW+1)'(hh[HW:1]) > (HW+1)'(POS_LIM)) ? OUT_MAX : DATA_W'(hh[HW:1]);
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [QUO_W:0] qq;
    quo_t           mg;
    assign qq = {1'b0, quo[l]} + (QUO_W+1)'(1);
    assign mg = qq[QUO_W:1];

    always_comb begin
      if (side.degen) begin
        lv[l] = !side.nz[l] ? '0 : (side.neg[l] ? OUT_MIN : OUT_MAX);
      end else if (!side.neg[l]) begin
        lv[l] = (side.ovf[l] || mg > POS_LIM) ? OUT_MAX : DATA_W'(mg);
      end else begin
        lv[l] = (side.ovf[l] || mg > NEG_LIM) ? OUT_MIN : -DATA_W'(mg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
    if (en) begin
      case_taken <= side.cs;
      degenerate <= side.degen;
      case (side.cs)
        CASE_TRACE: begin
          quat_x <= lv[0]; quat_y <= lv[1]; quat_z <= lv[2]; quat_w <= diag;
        end
        CASE_X: begin
          quat_x <= diag; quat_y <= lv[0]; quat_z <= lv[1]; quat_w <= lv[2];
        end
        CASE_Y: begin
          quat_x <= lv[0]; quat_y <= diag; quat_z <= lv[1]; quat_w <= lv[2];
        end
        default: begin
          quat_x <= lv[0]; quat_y <= lv[1]; quat_z <= diag; quat_w <= lv[2];
        end
      endcase
    end
  end

endmodule

// ===== src/rotation_matrix_to_quaternion_top.sv =====
// Rotation matrix to unit quaternion, fully pipelined.
// Pipeline stages, in order: front stage, one square-root stage per root bit,
// 35 divider stages, output stage.
// Throughput: one matrix per cycle; the whole pipe holds while the output waits.
// Reset (synchronous, active high) clears the valid bits only; no clearing pass.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rmq_mat_if.sink   mat,
  rmq_quat_if.source quat
);

  localparam int RW = rad_w(FRAC_BITS);
  localparam int HW = root_w(FRAC_BITS);

  logic              en;
  data_t [ELEMS-1:0] elem;
  logic              f_valid, s_valid, d_valid;
  logic [RW-1:0]     rad;
  tag_t              f_tag, s_tag;
  logic [HW-1:0]     root, d_h;
  side_t             d_side;
  quo_t [LANES-1:0]  d_quo;

  assign en        = !quat.valid || quat.ready;
  assign mat.ready = en;
  assign elem      = {mat.row2_col2, mat.row2_col1, mat.row2_col0,
                      mat.row1_col2, mat.row1_col1, mat.row1_col0,
                      mat.row0_col2, mat.row0_col1, mat.row0_col0};

  rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
    .clk, .rst, .en, .in_valid(mat.valid), .elem,
    .valid(f_valid), .rad, .tag(f_tag)
  );

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .RW(RW), .HW(HW)) u_sqrt (
    .clk, .rst, .en, .in_valid(f_valid), .rad, .in_tag(f_tag),
    .valid(s_valid), .root, .tag(s_tag)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS), .HW(HW)) u_div (
    .clk, .rst, .en, .in_valid(s_valid), .root, .in_tag(s_tag),
    .valid(d_valid), .h(d_h), .side(d_side), .quo(d_quo)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS), .HW(HW)) u_back (
    .clk, .rst, .en, .in_valid(d_valid), .h(d_h), .side(d_side), .quo(d_quo),
    .valid(quat.valid), .quat_x(quat.quat_x), .quat_y(quat.quat_y),
    .quat_z(quat.quat_z), .quat_w(quat.quat_w),
    .case_taken(quat.case_taken), .degenerate(quat.degenerate)
  );

endmodule
